// ----- rtl/small_swap_to_front_cache_core_macros.svh -----
// Assertion macros used by the checker file of the cache core.
`ifndef SMALL_SWAP_TO_FRONT_CACHE_CORE_MACROS_SVH
`define SMALL_SWAP_TO_FRONT_CACHE_CORE_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define SSFC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssfc assertion failed");

// Property checked on every rising clock edge, reset included.
`define SSFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ssfc assertion failed");

`endif

// ----- rtl/ssfc_pkg.sv -----
`timescale 1ns / 1ps
package ssfc_pkg;

  localparam int REQ_W = 2;
  localparam int KEY_W = 32;
  localparam int VER_W = 64;
  localparam int HND_W = 32;

  localparam int DEFAULT_CAPACITY = 4;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ssfc_cmd_t;

endpackage

// ----- rtl/ssfc_if.sv -----
`timescale 1ns / 1ps
interface ssfc_req_if;
  import ssfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] path_key;
  logic [VER_W-1:0] asset_version;
  logic [HND_W-1:0] payload_handle;

  modport source (output valid, req_type, path_key, asset_version, payload_handle,
                  input ready);
  modport sink (input valid, req_type, path_key, asset_version, payload_handle,
                output ready);
endinterface

interface ssfc_rsp_if;
  import ssfc_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [HND_W-1:0] handle_out;

  modport source (output valid, hit, handle_out, input ready);
  modport sink (input valid, hit, handle_out, output ready);
endinterface

// ----- rtl/small_swap_to_front_cache_core.sv -----
`timescale 1ns / 1ps
// Swap-to-front cache of CAPACITY entries keyed by path key and version.
// Each request (lookup, store or clear) returns exactly one response, in
// order. A request is first registered, then every entry is compared in
// parallel and the slots are updated, which also loads the response
// register. A new request is taken only after the previous one has updated
// the slots; a stalled response holds the update step until its register frees.
module small_swap_to_front_cache_core #(
  parameter int CAPACITY = ssfc_pkg::DEFAULT_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  ssfc_req_if.sink in_req,
  ssfc_rsp_if.source out_rsp
);
  import ssfc_pkg::*;

  ssfc_cmd_t cmd;

  ssfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  ssfc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .req_type       (in_req.req_type),
    .path_key       (in_req.path_key),
    .asset_version  (in_req.asset_version),
    .payload_handle (in_req.payload_handle),
    .hit            (out_rsp.hit),
    .handle_out     (out_rsp.handle_out)
  );

endmodule

// ----- rtl/ssfc_ctrl.sv -----
`timescale 1ns / 1ps
module ssfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ssfc_pkg::ssfc_cmd_t cmd
);
  import ssfc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result register must be free, or freed in this cycle, before the update.
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/ssfc_datapath.sv -----
`timescale 1ns / 1ps
module ssfc_datapath #(
  parameter int CAPACITY = ssfc_pkg::DEFAULT_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ssfc_pkg::ssfc_cmd_t        cmd,
  input  logic [ssfc_pkg::REQ_W-1:0] req_type,
  input  logic [ssfc_pkg::KEY_W-1:0] path_key,
  input  logic [ssfc_pkg::VER_W-1:0] asset_version,
  input  logic [ssfc_pkg::HND_W-1:0] payload_handle,
  output logic                       hit,
  output logic [ssfc_pkg::HND_W-1:0] handle_out
);
  import ssfc_pkg::*;

  logic [REQ_W-1:0] req_r;
  logic [KEY_W-1:0] key_r;
  logic [VER_W-1:0] ver_r;
  logic [HND_W-1:0] hnd_r;

  logic [KEY_W-1:0] slot_key_r [CAPACITY];
  logic [VER_W-1:0] slot_ver_r [CAPACITY];
  logic [HND_W-1:0] slot_hnd_r [CAPACITY];
  logic [KEY_W-1:0] slot_key_nxt [CAPACITY];
  logic [VER_W-1:0] slot_ver_nxt [CAPACITY];
  logic [HND_W-1:0] slot_hnd_nxt [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;

  logic [CAPACITY-1:0] key_eq;
  logic [CAPACITY-1:0] hit_vec;
  logic                found;
  logic                after_rm;
  logic [KEY_W-1:0]    hit_key;
  logic [VER_W-1:0]    hit_ver;
  logic [HND_W-1:0]    hit_hnd;

  logic             hit_r, hit_nxt;
  logic [HND_W-1:0] handle_r, handle_nxt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= req_type;
      key_r <= path_key;
      ver_r <= asset_version;
      hnd_r <= payload_handle;
    end
  end

  // Valid entries always form a prefix, and store keeps keys unique, so at
  // most one entry matches a key.
  always_comb begin
    found   = 1'b0;
    hit_key = '0;
    hit_ver = '0;
    hit_hnd = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      key_eq[i]  = valid_r[i] && (slot_key_r[i] == key_r);
      hit_vec[i] = key_eq[i] && (slot_ver_r[i] == ver_r) && !found;
      found      = found | hit_vec[i];
      if (hit_vec[i]) begin
        hit_key = hit_key | slot_key_r[i];
        hit_ver = hit_ver | slot_ver_r[i];
        hit_hnd = hit_hnd | slot_hnd_r[i];
      end
    end
  end

  always_comb begin
    slot_key_nxt = slot_key_r;
    slot_ver_nxt = slot_ver_r;
    slot_hnd_nxt = slot_hnd_r;
    valid_nxt    = valid_r;
    after_rm     = 1'b0;
    case (req_r)
      REQ_LOOKUP: begin
        if (found) begin
          slot_key_nxt[0] = hit_key;
          slot_ver_nxt[0] = hit_ver;
          slot_hnd_nxt[0] = hit_hnd;
          for (int i = 1; i < CAPACITY; i++) begin
            if (hit_vec[i]) begin
              slot_key_nxt[i] = slot_key_r[0];
              slot_ver_nxt[i] = slot_ver_r[0];
              slot_hnd_nxt[i] = slot_hnd_r[0];
            end
          end
        end
      end
      REQ_STORE: begin
        slot_key_nxt[0] = key_r;
        slot_ver_nxt[0] = ver_r;
        slot_hnd_nxt[0] = hnd_r;
        valid_nxt[0]    = 1'b1;
        // Slots up to the removed entry shift down by one; slots past it stay.
        for (int j = 1; j < CAPACITY; j++) begin
          after_rm = after_rm | key_eq[j-1];
          if (!after_rm) begin
            slot_key_nxt[j] = slot_key_r[j-1];
            slot_ver_nxt[j] = slot_ver_r[j-1];
            slot_hnd_nxt[j] = slot_hnd_r[j-1];
            valid_nxt[j]    = valid_r[j-1];
          end
        end
      end
      REQ_CLEAR: begin
        valid_nxt = '0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  assign hit_nxt    = (req_r == REQ_LOOKUP) && found;
  assign handle_nxt = hit_nxt ? hit_hnd : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.exec) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      slot_key_r <= slot_key_nxt;
      slot_ver_r <= slot_ver_nxt;
      slot_hnd_r <= slot_hnd_nxt;
      hit_r      <= hit_nxt;
      handle_r   <= handle_nxt;
    end
  end

  assign hit        = hit_r;
  assign handle_out = handle_r;

endmodule

// ----- rtl/ssfc_checker.sv -----
`timescale 1ns / 1ps
`include "small_swap_to_front_cache_core_macros.svh"
module ssfc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_hit,
  input logic [ssfc_pkg::HND_W-1:0] out_handle
);
  import ssfc_pkg::*;

  // A response waiting to be taken stays offered with the same contents.
  `SSFC_ASSERT(a_rsp_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_handle))

  // A response without a hit never carries a handle.
  `SSFC_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_hit |-> out_handle == '0)

  // After a request is taken, in_ready is low in the next cycle.
  `SSFC_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // Reset leaves no response pending.
  `SSFC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind small_swap_to_front_cache_core ssfc_checker u_ssfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_hit    (out_rsp.hit),
  .out_handle (out_rsp.handle_out)
);
